[hw/rtl/rc5_pkg.sv]
// Shared constants, types and rotate helpers for the RC5-32 block cipher.
// Used by the channel interfaces and by the top, controller and datapath modules.
`default_nettype none

package rc5_pkg;

	// Number of rounds; the key table holds 2*ROUNDS+2 words
	localparam int unsigned RC5_ROUNDS = 12;

	// Key schedule magic constants
	localparam logic [31:0] MAGIC_P = 32'hb7e15163;
	localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

	// The 128-bit key is four 32-bit words
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned KW_AW     = 2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_MIX_A,
		ST_MIX_B,
		ST_CRYPT,
		ST_OUT
	} rc5_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;   // capture input word
		logic load_key;  // copy key registers, restart schedule
		logic init_wr;   // write P + k*Q into the table
		logic mix_a;     // mixing step, table side
		logic mix_b;     // mixing step, key word side
		logic crypt;     // one half-round
		logic dec;       // direction of the current word
		logic odd;       // half-round updates B
		logic plain;     // whitening add/subtract only
		logic load_out;  // move result into the output register
	} rc5_cmd_t;

	// Rotate left by the low five bits
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

	// Rotate right by the low five bits
	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} >> n;
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rc5_intf.sv]
// Valid/ready channel interfaces for the RC5 cipher: input, result and config.
// Depends on rc5_pkg for the register index width.
`default_nettype none

interface rc5_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic        decrypt;

	modport source (output valid, word_a, word_b, decrypt, input ready);
	modport sink (input valid, word_a, word_b, decrypt, output ready);
endinterface

interface rc5_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_a;
	logic [31:0] out_b;

	modport source (output valid, out_a, out_b, input ready);
	modport sink (input valid, out_a, out_b, output ready);
endinterface

interface rc5_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rc5_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [63:0]                    wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

[hw/rtl/rc5_block_cipher.sv]
// RC5-32 block cipher: one 64-bit word in, one 64-bit word out per item.
// One half-round per cycle through the single round key RAM read port; one item at a time.
// After a key write the next item first expands the key: 2*ROUNDS+2 table fill steps, then
// 3*(2*ROUNDS+2) mixing steps, each split into a table-side and a key-word-side state.
// Reset (arst_n low) clears the key to zero and marks the round key table stale.
`default_nettype none

module rc5_block_cipher #(
	parameter int unsigned ROUNDS = rc5_pkg::RC5_ROUNDS
) (
	input  logic      clk,
	input  logic      arst_n,
	rc5_in_if.sink    in_ch,
	rc5_out_if.source out_ch,
	rc5_cfg_if.sink   cfg
);

	import rc5_pkg::*;

	localparam int unsigned NKEYS = 2 * ROUNDS + 2;
	localparam int unsigned KAW   = $clog2(NKEYS);

	rc5_cmd_t         cmd;
	logic [KAW-1:0]   ram_raddr;
	logic [KAW-1:0]   ram_waddr;
	logic [KW_AW-1:0] kw_idx;
	logic             key_wr;

	// Config writes are always taken; only key register indexes have effect
	assign cfg.ready = 1'b1;
	assign key_wr    = cfg.valid
		&& ((cfg.reg_index == REG_KEY_LOW) || (cfg.reg_index == REG_KEY_HIGH));

	rc5_ctrl #(
		.ROUNDS (ROUNDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_decrypt (in_ch.decrypt),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.key_wr     (key_wr),
		.cmd        (cmd),
		.ram_raddr  (ram_raddr),
		.ram_waddr  (ram_waddr),
		.kw_idx     (kw_idx)
	);

	rc5_datapath #(
		.ROUNDS (ROUNDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_raddr (ram_raddr),
		.ram_waddr (ram_waddr),
		.kw_idx    (kw_idx),
		.word_a    (in_ch.word_a),
		.word_b    (in_ch.word_b),
		.key_wr    (key_wr),
		.reg_index (cfg.reg_index),
		.wdata     (cfg.wdata),
		.out_a     (out_ch.out_a),
		.out_b     (out_ch.out_b)
	);

endmodule

`default_nettype wire

[hw/rtl/rc5_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
`default_nettype none

module rc5_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 26,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/rc5_ctrl.sv]
// Controller for the RC5 cipher: sequences key expansion and half-rounds.
// Depends on rc5_pkg for the state type and the command struct.
`default_nettype none

module rc5_ctrl #(
	parameter int unsigned ROUNDS = rc5_pkg::RC5_ROUNDS,
	localparam int unsigned NKEYS = 2 * ROUNDS + 2,
	localparam int unsigned KAW   = $clog2(NKEYS),
	localparam int unsigned MIXES = 3 * NKEYS,
	localparam int unsigned MCW   = $clog2(MIXES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_decrypt,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         key_wr,
	output rc5_pkg::rc5_cmd_t            cmd,
	output logic [KAW-1:0]               ram_raddr,
	output logic [KAW-1:0]               ram_waddr,
	output logic [rc5_pkg::KW_AW-1:0]    kw_idx
);

	import rc5_pkg::*;

	localparam logic [KAW-1:0] IDX_LAST = KAW'(NKEYS - 1);
	localparam logic [MCW-1:0] MIX_LAST = MCW'(MIXES - 1);

	rc5_state_t        state_q, state_d;
	logic [KAW-1:0]    idx_q, idx_d;
	logic [MCW-1:0]    mix_q;
	logic [KW_AW-1:0]  kw_q;
	logic              dec_q;
	logic              sched_q;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;
	logic              idx_last;
	logic              mix_last;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign idx_last = (idx_q == IDX_LAST);
	assign mix_last = (mix_q == MIX_LAST);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = sched_q ? ST_CRYPT : ST_INIT;
				end
			end
			ST_INIT: begin
				if (idx_last) begin
					state_d = ST_MIX_A;
				end
			end
			ST_MIX_A: state_d = ST_MIX_B;
			ST_MIX_B: begin
				if (mix_last) begin
					state_d = ST_CRYPT;
				end else begin
					state_d = ST_MIX_A;
				end
			end
			ST_CRYPT: begin
				if (dec_q ? (idx_q == '0) : idx_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table index for the next cycle; the RAM is read at this address, so its registered data belongs to idx_q
	always_comb begin
		idx_d = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d = (sched_q && in_decrypt) ? IDX_LAST : '0;
				end
			end
			ST_INIT: idx_d = idx_last ? '0 : idx_q + 1'b1;
			ST_MIX_B: begin
				if (mix_last) begin
					idx_d = dec_q ? IDX_LAST : '0;
				end else begin
					idx_d = idx_last ? '0 : idx_q + 1'b1;
				end
			end
			ST_CRYPT: idx_d = dec_q ? idx_q - 1'b1 : idx_q + 1'b1;
			default: idx_d = idx_q;
		endcase
	end

	// Command outputs
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.load_in  = accept;
		cmd.load_key = accept && !sched_q;
		cmd.init_wr  = (state_q == ST_INIT);
		cmd.mix_a    = (state_q == ST_MIX_A);
		cmd.mix_b    = (state_q == ST_MIX_B);
		cmd.crypt    = (state_q == ST_CRYPT);
		cmd.dec      = dec_q;
		cmd.odd      = idx_q[0];
		cmd.plain    = (idx_q < KAW'(2));
		cmd.load_out = (state_q == ST_OUT) && out_free;
	end

	assign ram_raddr = idx_d;
	assign ram_waddr = idx_q;
	assign kw_idx    = kw_q;
	assign out_valid = out_valid_q;

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mix_q       <= '0;
			kw_q        <= '0;
			dec_q       <= 1'b0;
			sched_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (accept) begin
				dec_q <= in_decrypt;
				mix_q <= '0;
				kw_q  <= '0;
			end else if (state_q == ST_MIX_B) begin
				mix_q <= mix_q + 1'b1;
				kw_q  <= kw_q + 1'b1;
			end
			// a key write invalidates the expanded table
			if (key_wr) begin
				sched_q <= 1'b0;
			end else if ((state_q == ST_MIX_B) && mix_last) begin
				sched_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rc5_datapath.sv]
// Datapath for the RC5 cipher: key registers, round key RAM, mixing and rounds.
// Depends on rc5_pkg and rc5_ram; driven by commands from rc5_ctrl.
`default_nettype none

module rc5_datapath #(
	parameter int unsigned ROUNDS = rc5_pkg::RC5_ROUNDS,
	localparam int unsigned NKEYS = 2 * ROUNDS + 2,
	localparam int unsigned KAW   = $clog2(NKEYS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rc5_pkg::rc5_cmd_t             cmd,
	input  logic [KAW-1:0]                ram_raddr,
	input  logic [KAW-1:0]                ram_waddr,
	input  logic [rc5_pkg::KW_AW-1:0]     kw_idx,
	input  logic [31:0]                   word_a,
	input  logic [31:0]                   word_b,
	input  logic                          key_wr,
	input  logic [rc5_pkg::CFG_IDX_W-1:0] reg_index,
	input  logic [63:0]                   wdata,
	output logic [31:0]                   out_a,
	output logic [31:0]                   out_b
);

	import rc5_pkg::*;

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [31:0] kw_q [KEY_WORDS];
	logic [31:0] acc_q;
	logic [31:0] ma_q;
	logic [31:0] mb_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] out_a_q;
	logic [31:0] out_b_q;

	logic        ram_we;
	logic [31:0] ram_wdata;
	logic [31:0] rkey;
	logic [31:0] mix_a_new;
	logic [31:0] mix_ab;
	logic [31:0] mix_b_new;
	logic [31:0] enc_a;
	logic [31:0] enc_b;
	logic [31:0] dec_a;
	logic [31:0] dec_b;

	// Round key table
	assign ram_we    = cmd.init_wr || cmd.mix_a;
	assign ram_wdata = cmd.init_wr ? acc_q : mix_a_new;

	rc5_ram #(
		.WIDTH (32),
		.DEPTH (NKEYS)
	) u_rkeys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rkey)
	);

	// Key schedule mixing, split into a table-side and a key-word-side step
	assign mix_a_new = rotl32(rkey + ma_q + mb_q, 5'd3);
	assign mix_ab    = ma_q + mb_q;
	assign mix_b_new = rotl32(kw_q[kw_idx] + mix_ab, mix_ab[4:0]);

	// Half-round, encrypt direction
	assign enc_a = cmd.plain ? a_q + rkey : rotl32(a_q ^ b_q, b_q[4:0]) + rkey;
	assign enc_b = cmd.plain ? b_q + rkey : rotl32(b_q ^ a_q, a_q[4:0]) + rkey;

	// Half-round, decrypt direction
	assign dec_a = cmd.plain ? a_q - rkey : rotr32(a_q - rkey, b_q[4:0]) ^ b_q;
	assign dec_b = cmd.plain ? b_q - rkey : rotr32(b_q - rkey, a_q[4:0]) ^ a_q;

	// Key registers, written from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (key_wr) begin
			case (reg_index)
				REG_KEY_LOW:  key_low_q  <= wdata;
				REG_KEY_HIGH: key_high_q <= wdata;
				default: ;
			endcase
		end
	end

	// Schedule working state
	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			kw_q[0] <= key_low_q[31:0];
			kw_q[1] <= key_low_q[63:32];
			kw_q[2] <= key_high_q[31:0];
			kw_q[3] <= key_high_q[63:32];
			acc_q   <= MAGIC_P;
			ma_q    <= '0;
			mb_q    <= '0;
		end else begin
			if (cmd.init_wr) begin
				acc_q <= acc_q + MAGIC_Q;
			end
			if (cmd.mix_a) begin
				ma_q <= mix_a_new;
			end
			if (cmd.mix_b) begin
				mb_q         <= mix_b_new;
				kw_q[kw_idx] <= mix_b_new;
			end
		end
	end

	// Cipher word registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q <= word_a;
			b_q <= word_b;
		end else if (cmd.crypt) begin
			if (cmd.odd) begin
				b_q <= cmd.dec ? dec_b : enc_b;
			end else begin
				a_q <= cmd.dec ? dec_a : enc_a;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_a_q <= a_q;
			out_b_q <= b_q;
		end
	end

	assign out_a = out_a_q;
	assign out_b = out_b_q;

endmodule

`default_nettype wire
